>>> rtl/psm_pkg.sv
// Package for the p-code stack machine executor: opcodes, ALU codes, states.
// Depends on nothing; used by pcode_stack_machine_executor.
package psm_pkg;

	typedef enum logic [2:0] {
		OP_LIT = 3'd0,
		OP_OPR = 3'd1,
		OP_LOD = 3'd2,
		OP_STO = 3'd3,
		OP_CAL = 3'd4,
		OP_INT = 3'd5,
		OP_JMP = 3'd6,
		OP_JPC = 3'd7
	} opcode_t;

	localparam logic [30:0] OPR_RET = 31'd0;
	localparam logic [30:0] OPR_NEG = 31'd1;
	localparam logic [30:0] OPR_ADD = 31'd2;
	localparam logic [30:0] OPR_SUB = 31'd3;
	localparam logic [30:0] OPR_MUL = 31'd4;
	localparam logic [30:0] OPR_DIV = 31'd5;
	localparam logic [30:0] OPR_ODD = 31'd6;
	localparam logic [30:0] OPR_EQ  = 31'd7;
	localparam logic [30:0] OPR_NE  = 31'd8;
	localparam logic [30:0] OPR_LT  = 31'd9;
	localparam logic [30:0] OPR_GE  = 31'd10;
	localparam logic [30:0] OPR_GT  = 31'd11;
	localparam logic [30:0] OPR_LE  = 31'd12;
	localparam logic [30:0] OPR_NOT = 31'd13;
	localparam logic [30:0] OPR_AND = 31'd14;
	localparam logic [30:0] OPR_OR  = 31'd15;

	// Sequencer states. Read data arrives the cycle after its address.
	typedef enum logic [4:0] {
		ST_CLEAR,     // writes zero to words 1..3 after reset
		ST_IDLE,
		ST_RD_TOP,    // read word at top
		ST_GOT_TOP,
		ST_RD_NT,     // read word below top
		ST_GOT_NT,
		ST_DIV,       // one quotient bit a cycle
		ST_DIV_FIX,
		ST_WR_RES,
		ST_WALK,      // one static link a step
		ST_WALK_RD,
		ST_ADDR_RD,
		ST_LOD_WR,
		ST_STO_WR,
		ST_CAL_W1,
		ST_CAL_W2,
		ST_CAL_W3,
		ST_RET_RA,
		ST_RET_DL,
		ST_RET_END,
		ST_JPC_RD,
		ST_DONE
	} state_t;

endpackage

>>> rtl/pcode_stack_machine_executor.sv
// A load, store or call walks one static link per step through the memory read port,
// up to LEVEL_MAX links; div runs 32 restoring steps. One instruction at a time: a new
// request is taken only in idle, once the last result has been taken.
// Reset: asynchronous, active low; a clearing pass zeroes stack words 1 to 3 before the
// first request is taken. top=3, base=1, pc=0. Depends on psm_pkg.
module pcode_stack_machine_executor
	import psm_pkg::*;
#(
	parameter int STACK_DEPTH = 1024,
	parameter int CODE_DEPTH  = 1024,
	parameter int LEVEL_MAX   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: opcode[2:0], level_diff[8:3], operand[39:9].
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: next_pc[9:0], store_seen[10], store_value[42:11], halted[43],
	// divide_by_zero[44], stack_fault[45], zero fill to 48 bits.
	output logic [47:0] m_tdata
);

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(CODE_DEPTH);
	localparam int LW = $clog2(LEVEL_MAX + 1);

	// Stack memory, one read and one write port, registered read data.
	logic [31:0] mem [STACK_DEPTH];
	logic [SW-1:0] rd_addr, wr_addr;
	logic [31:0] wr_data, rd_q;
	logic wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	state_t state_q, state_nx;

	logic [SW-1:0] top_q, base_q;
	logic [CW-1:0] pc_q;
	logic [2:0] op_q;
	logic [30:0] a_q;
	logic [31:0] x_q, y_q;
	logic [LW-1:0] walk_q;
	logic [SW-1:0] link_q;
	logic [CW-1:0] npc_q;
	logic [31:0] sv_q;
	logic st_q, dz_q, fault_q;
	logic [1:0] clr_q;
	logic [5:0] dcnt_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic neg_q;
	logic out_v_q;
	logic [47:0] out_q;

	// Index reduction with fault detect on signed 34-bit values.
	function automatic logic [SW:0] sidx(input logic signed [33:0] v);
		logic f;
		logic signed [33:0] r;
		begin
			f = (v < 0) || (v >= 34'(STACK_DEPTH));
			r = v & 34'(STACK_DEPTH - 1);
			sidx = {f, r[SW-1:0]};
		end
	endfunction

	logic [SW:0] i_top_p1, i_top_m1, i_top_p2, i_top_p3, i_top_pa, i_link, i_addr;
	logic [SW:0] i_base_m1, i_nt3, i_nt2, i_dl;

	always_comb begin
		i_top_p1 = sidx(34'($signed({1'b0, top_q})) + 34'sd1);
		i_top_p2 = sidx(34'($signed({1'b0, top_q})) + 34'sd2);
		i_top_p3 = sidx(34'($signed({1'b0, top_q})) + 34'sd3);
		i_top_m1 = sidx(34'($signed({1'b0, top_q})) - 34'sd1);
		i_top_pa = sidx(34'($signed({1'b0, top_q})) + 34'($signed({1'b0, a_q})));
		i_link   = sidx(34'($signed(rd_q)));
		i_addr   = sidx(34'($signed({1'b0, link_q})) + 34'($signed({1'b0, a_q})));
		i_base_m1 = sidx(34'($signed({1'b0, base_q})) - 34'sd1);
		i_nt3    = sidx(34'($signed({1'b0, i_base_m1[SW-1:0]})) + 34'sd3);
		i_nt2    = sidx(34'($signed({1'b0, i_base_m1[SW-1:0]})) + 34'sd2);
		i_dl     = sidx(34'($signed(rd_q)));
	end

	// Shared ALU for two-operand operations.
	logic [31:0] alu_r;
	logic signed [31:0] sx, sy;
	assign sx = x_q;
	assign sy = y_q;
	always_comb begin
		unique case (a_q)
			OPR_ADD: alu_r = x_q + y_q;
			OPR_SUB: alu_r = x_q - y_q;
			OPR_MUL: alu_r = x_q * y_q;
			OPR_EQ:  alu_r = {31'd0, sx == sy};
			OPR_NE:  alu_r = {31'd0, sx != sy};
			OPR_LT:  alu_r = {31'd0, sx < sy};
			OPR_GE:  alu_r = {31'd0, sx >= sy};
			OPR_GT:  alu_r = {31'd0, sx > sy};
			OPR_LE:  alu_r = {31'd0, sx <= sy};
			OPR_AND: alu_r = {31'd0, (x_q != 0) && (y_q != 0)};
			OPR_OR:  alu_r = {31'd0, (x_q != 0) || (y_q != 0)};
			default: alu_r = quo_q;
		endcase
	end

	// Divider trial subtract.
	logic [32:0] trial;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	logic acc;
	assign acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	logic [CW-1:0] pc_inc;
	assign pc_inc = pc_q + CW'(1);

	logic unary;
	assign unary = (a_q == OPR_NEG) || (a_q == OPR_ODD) || (a_q == OPR_NOT);

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:   state_nx = (clr_q == 2'd2) ? ST_IDLE : ST_CLEAR;
			ST_IDLE: begin
				if (acc) begin
					unique case (opcode_t'(s_tdata[2:0]))
						OP_LIT, OP_INT, OP_JMP: state_nx = ST_DONE;
						OP_OPR: begin
							if (s_tdata[39:9] == OPR_RET) begin
								state_nx = ST_RET_RA;
							end else if (s_tdata[39:9] > OPR_OR) begin
								state_nx = ST_DONE;
							end else begin
								state_nx = ST_RD_TOP;
							end
						end
						OP_LOD, OP_CAL: state_nx = ST_WALK;
						OP_STO:  state_nx = ST_RD_TOP;
						OP_JPC:  state_nx = ST_JPC_RD;
						default: state_nx = ST_DONE;
					endcase
				end
			end
			ST_RD_TOP:  state_nx = ST_GOT_TOP;
			ST_GOT_TOP: begin
				if (op_q == OP_STO) begin
					state_nx = ST_WALK;
				end else if (unary) begin
					state_nx = ST_DONE;
				end else begin
					state_nx = ST_RD_NT;
				end
			end
			ST_RD_NT:   state_nx = ST_GOT_NT;
			ST_GOT_NT: begin
				if (a_q == OPR_DIV) begin
					state_nx = (y_q == 32'd0) ? ST_DONE : ST_DIV;
				end else begin
					state_nx = ST_WR_RES;
				end
			end
			ST_DIV:     state_nx = (dcnt_q == 6'd31) ? ST_DIV_FIX : ST_DIV;
			ST_DIV_FIX: state_nx = ST_WR_RES;
			ST_WR_RES:  state_nx = ST_DONE;
			ST_WALK:    state_nx = (walk_q == '0) ? ST_ADDR_RD : ST_WALK_RD;
			ST_WALK_RD: state_nx = ST_WALK;
			ST_ADDR_RD: begin
				unique case (opcode_t'(op_q))
					OP_LOD:  state_nx = ST_LOD_WR;
					OP_STO:  state_nx = ST_STO_WR;
					default: state_nx = ST_CAL_W1;
				endcase
			end
			ST_LOD_WR:  state_nx = ST_DONE;
			ST_STO_WR:  state_nx = ST_DONE;
			ST_CAL_W1:  state_nx = ST_CAL_W2;
			ST_CAL_W2:  state_nx = ST_CAL_W3;
			ST_CAL_W3:  state_nx = ST_DONE;
			ST_RET_RA:  state_nx = ST_RET_DL;
			ST_RET_DL:  state_nx = ST_RET_END;
			ST_RET_END: state_nx = ST_DONE;
			ST_JPC_RD:  state_nx = ST_DONE;
			ST_DONE:    state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		rd_addr = top_q;
		wr_en = 1'b0;
		wr_addr = top_q;
		wr_data = x_q;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = SW'(clr_q) + SW'(1);
				wr_data = '0;
			end
			ST_RD_TOP:  rd_addr = top_q;
			ST_RD_NT:   rd_addr = i_top_m1[SW-1:0];
			ST_WALK:    rd_addr = link_q;
			ST_ADDR_RD: rd_addr = i_addr[SW-1:0];
			ST_JPC_RD:  rd_addr = top_q;
			ST_RET_RA:  rd_addr = i_nt3[SW-1:0];
			ST_RET_DL:  rd_addr = i_nt2[SW-1:0];
			ST_WR_RES: begin
				wr_en = 1'b1;
				wr_addr = i_top_m1[SW-1:0];
				wr_data = alu_r;
			end
			ST_LOD_WR: begin
				wr_en = 1'b1;
				wr_addr = i_top_p1[SW-1:0];
				wr_data = rd_q;
			end
			ST_STO_WR: begin
				wr_en = 1'b1;
				wr_addr = i_addr[SW-1:0];
				wr_data = x_q;
			end
			ST_CAL_W1: begin
				wr_en = 1'b1;
				wr_addr = i_top_p1[SW-1:0];
				wr_data = 32'(link_q);
			end
			ST_CAL_W2: begin
				wr_en = 1'b1;
				wr_addr = i_top_p2[SW-1:0];
				wr_data = 32'(base_q);
			end
			ST_CAL_W3: begin
				wr_en = 1'b1;
				wr_addr = i_top_p3[SW-1:0];
				wr_data = 32'(npc_q);
			end
			ST_DONE: begin
				// A literal goes one word above the top; a unary result replaces the top.
				wr_en = (op_q == OP_LIT) ||
					((op_q == OP_OPR) && unary && (a_q != OPR_RET));
				wr_addr = (op_q == OP_LIT) ? i_top_p1[SW-1:0] : top_q;
				wr_data = x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			top_q <= SW'(3);
			base_q <= SW'(1);
			pc_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 2'd1;
			end
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						op_q <= s_tdata[2:0];
						a_q <= s_tdata[39:9];
						npc_q <= pc_inc;
						st_q <= 1'b0;
						sv_q <= '0;
						dz_q <= 1'b0;
						fault_q <= 1'b0;
						link_q <= base_q;
						walk_q <= (s_tdata[8:3] > 6'(LEVEL_MAX)) ?
							LW'(LEVEL_MAX) : LW'(s_tdata[8:3]);
						if (opcode_t'(s_tdata[2:0]) == OP_LIT) begin
							x_q <= {1'b0, s_tdata[39:9]};
						end
					end
				end
				ST_GOT_TOP: begin
					y_q <= rd_q;
					// For a store the operand is an address, so the word passes unchanged.
					if (op_q == OP_OPR) begin
						unique case (a_q)
							OPR_NEG: x_q <= 32'd0 - rd_q;
							OPR_ODD: x_q <= {31'd0, rd_q[0]};
							OPR_NOT: x_q <= {31'd0, rd_q == 32'd0};
							default: x_q <= rd_q;
						endcase
					end else begin
						x_q <= rd_q;
					end
				end
				ST_GOT_NT: begin
					x_q <= rd_q;
					if (a_q == OPR_DIV && y_q == 32'd0) begin
						dz_q <= 1'b1;
					end
					quo_q <= rd_q[31] ? 32'd0 - rd_q : rd_q;
					dvs_q <= y_q[31] ? 32'd0 - y_q : y_q;
					rem_q <= '0;
					dcnt_q <= '0;
					neg_q <= rd_q[31] ^ y_q[31];
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], quo_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
				end
				ST_DIV_FIX: begin
					if (neg_q) begin
						quo_q <= 32'd0 - quo_q;
					end
				end
				ST_WALK: begin
					if (walk_q != '0) begin
						walk_q <= walk_q - LW'(1);
					end
				end
				ST_WALK_RD: begin
					link_q <= i_link[SW-1:0];
					fault_q <= fault_q | i_link[SW];
				end
				ST_ADDR_RD: begin
					// A call uses only the link itself, not link plus operand.
					if (op_q != OP_CAL) begin
						fault_q <= fault_q | i_addr[SW];
					end
				end
				ST_RET_RA: begin
					fault_q <= fault_q | i_base_m1[SW] | i_nt3[SW] | i_nt2[SW];
				end
				ST_RET_DL: begin
					npc_q <= rd_q[CW-1:0];
				end
				ST_RET_END: begin
					base_q <= i_dl[SW-1:0];
					fault_q <= fault_q | i_dl[SW];
					top_q <= i_base_m1[SW-1:0];
				end
				ST_JPC_RD: ;
				ST_CAL_W3: begin
					fault_q <= fault_q | i_top_p1[SW] | i_top_p2[SW] | i_top_p3[SW];
					base_q <= i_top_p1[SW-1:0];
					npc_q <= a_q[CW-1:0];
				end
				ST_DONE: begin
					logic [CW-1:0] np;
					logic f;
					logic [SW-1:0] nt;
					np = npc_q;
					f = fault_q;
					nt = top_q;
					unique case (opcode_t'(op_q))
						OP_LIT: begin
							nt = i_top_p1[SW-1:0];
							f = f | i_top_p1[SW];
						end
						OP_OPR: begin
							if (!unary && a_q >= OPR_ADD && a_q <= OPR_OR) begin
								nt = i_top_m1[SW-1:0];
								f = f | i_top_m1[SW];
							end
						end
						OP_LOD: begin
							nt = i_top_p1[SW-1:0];
							f = f | i_top_p1[SW];
						end
						OP_STO: begin
							nt = i_top_m1[SW-1:0];
							f = f | i_top_m1[SW];
						end
						OP_INT: begin
							nt = i_top_pa[SW-1:0];
							f = f | i_top_pa[SW];
						end
						OP_JMP: np = a_q[CW-1:0];
						OP_JPC: begin
							if (rd_q == 32'd0) begin
								np = a_q[CW-1:0];
							end
							nt = i_top_m1[SW-1:0];
							f = f | i_top_m1[SW];
						end
						default: ;
					endcase
					top_q <= nt;
					pc_q <= np;
					out_v_q <= 1'b1;
					out_q <= {2'b00, f, dz_q, np == '0, sv_q, st_q, 10'(np)};
				end
				default: ;
			endcase
			if (state_q == ST_ADDR_RD && op_q == OP_STO) begin
				st_q <= 1'b1;
				sv_q <= x_q;
			end
			if (state_q == ST_GOT_TOP && op_q == OP_STO) begin
				sv_q <= '0;
			end
		end
	end

endmodule

>>> rtl/psm_checker.sv
// Port-level checker for the p-code stack machine executor, with its bind.
// Depends on psm_pkg only for the house import style.
module psm_checker
	import psm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// A result waiting to be taken keeps the input closed.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input open while result waits");

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// Halted mirrors a zero next pc.
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[43] == (m_tdata[9:0] == 10'd0)))
		else $error("halted flag disagrees with next pc");

	// Store value is zero when no store took place.
	a_sv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[10] |-> m_tdata[42:11] == 32'd0)
		else $error("store value without store");

	// A request cannot produce its result in the following cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result too early");

endmodule

bind pcode_stack_machine_executor psm_checker u_psm_checker (.*);
